// File: design/assert_macros.svh
// Assertion macros shared by the shortest-path block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ddsp_pkg.sv
// ----------------------------------------------------------------------------
// ddsp_pkg
// Shared types and constants of the dense shortest-path block.
// ----------------------------------------------------------------------------
package ddsp_pkg;

   localparam int MaxVertices = 64;
   localparam int VertexBits  = $clog2(MaxVertices);
   localparam int CountBits   = VertexBits + 1;
   localparam int WeightBits  = 16;
   localparam int DistBits    = 22;
   localparam int EdgeBits    = 2 * VertexBits;
   localparam int EdgeDepth   = MaxVertices * MaxVertices;
   localparam int QueueDepth  = 2;
   localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Command passed from the front end to the engine.
   typedef struct packed {
      action_type             action;
      logic [VertexBits-1:0]  src;
      logic [VertexBits-1:0]  dst;
      logic [WeightBits-1:0]  weight;
      logic [CountBits-1:0]   count;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_INIT,
      ST_SCAN,
      ST_MARK,
      ST_RELAX_RD,
      ST_RELAX,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

endpackage

// File: design/ddsp_front.sv
// ----------------------------------------------------------------------------
// ddsp_front
// Accepts request items, clamps the vertex count, drops out-of-range edges
// and unknown actions, and queues commands for the engine.
// ----------------------------------------------------------------------------
module ddsp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [ddsp_pkg::VertexBits-1:0]   req_src_vertex,
   input  logic [ddsp_pkg::VertexBits-1:0]   req_dst_vertex,
   input  logic [ddsp_pkg::WeightBits-1:0]   req_edge_weight,
   input  logic [ddsp_pkg::CountBits-1:0]    vertex_count,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output ddsp_pkg::cmd_type                 cmd_data
);
`include "assert_macros.svh"

   ddsp_pkg::cmd_type                      queue_ff [ddsp_pkg::QueueDepth];
   logic [0:0]                             wr_ptr_ff, wr_ptr_in;
   logic [0:0]                             rd_ptr_ff, rd_ptr_in;
   logic [1:0]                             fill_ff, fill_in;
   logic [ddsp_pkg::CountBits-1:0]         count_n;
   ddsp_pkg::cmd_type                      new_cmd;
   logic                                   keep;
   logic                                   push, pop;

   always_comb begin
      if (vertex_count == '0) begin
         count_n = ddsp_pkg::CountBits'(1);
      end else if (vertex_count > ddsp_pkg::CountBits'(ddsp_pkg::MaxVertices)) begin
         count_n = ddsp_pkg::CountBits'(ddsp_pkg::MaxVertices);
      end else begin
         count_n = vertex_count;
      end
      new_cmd.action = ddsp_pkg::action_type'(req_action);
      new_cmd.src    = req_src_vertex;
      new_cmd.dst    = req_dst_vertex;
      new_cmd.weight = req_edge_weight;
      new_cmd.count  = count_n;
      case (new_cmd.action)
         ddsp_pkg::ACT_CLEAR: keep = 1'b1;
         ddsp_pkg::ACT_RUN:   keep = 1'b1;
         ddsp_pkg::ACT_ADD:   keep = ({1'b0, req_src_vertex} < count_n) &&
                                     ({1'b0, req_dst_vertex} < count_n);
         default:             keep = 1'b0;
      endcase
   end

   assign req_ready = (fill_ff != 2'(ddsp_pkg::QueueDepth));
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `ASSERT_CHECK(a_fill_bound, clock, reset, fill_ff <= 2'(ddsp_pkg::QueueDepth), "queue overfilled")
   `ASSERT_NEXT(a_push_counts, clock, reset, push && !pop, fill_ff == $past(fill_ff) + 2'd1, "push lost")
   `ASSERT_CHECK(a_ptr_fill, clock, reset, (fill_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff), "pointer mismatch")

endmodule

// File: design/ddsp_engine.sv
// ----------------------------------------------------------------------------
// ddsp_engine
// Carries out queued commands: edge store upkeep and the O(N^2) selection
// and relaxation scans of a run, then streams one result per vertex.
// ----------------------------------------------------------------------------
module ddsp_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  ddsp_pkg::cmd_type                 cmd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ddsp_pkg::VertexBits-1:0]   rsp_vertex,
   output logic [ddsp_pkg::DistBits-1:0]     rsp_distance,
   output logic                              rsp_reachable,
   output logic                              rsp_last
);
`include "assert_macros.svh"

   localparam int VB = ddsp_pkg::VertexBits;
   localparam int CB = ddsp_pkg::CountBits;
   localparam int DB = ddsp_pkg::DistBits;

   // Edge store: weight and presence in one memory, presence cleared by sweep.
   // The sweep also runs straight after reset, so no presence bit is ever unknown.
   logic [ddsp_pkg::WeightBits:0]   edge_mem [ddsp_pkg::EdgeDepth];
   logic [ddsp_pkg::WeightBits:0]   edge_rd_ff;
   logic [DB-1:0]                   dist_mem [ddsp_pkg::MaxVertices];
   logic [DB-1:0]                   dist_rd_ff;
   logic [ddsp_pkg::MaxVertices-1:0] reach_ff, reach_in;
   logic [ddsp_pkg::MaxVertices-1:0] visited_ff, visited_in;

   ddsp_pkg::state_type             state_ff, state_in;
   ddsp_pkg::cmd_type               cmd_ff, cmd_in;
   logic [ddsp_pkg::EdgeBits:0]     sweep_ff, sweep_in;
   logic [CB-1:0]                   idx_ff, idx_in;
   logic [CB-1:0]                   round_ff, round_in;
   logic [DB:0]                     low_ff, low_in;
   logic [VB-1:0]                   pick_ff, pick_in;
   logic [DB-1:0]                   pick_dist_ff, pick_dist_in;
   logic [VB-1:0]                   chosen_ff, chosen_in;

   logic                            edge_we;
   logic [ddsp_pkg::EdgeBits-1:0]   edge_wa;
   logic [ddsp_pkg::WeightBits:0]   edge_wd;
   logic [ddsp_pkg::EdgeBits-1:0]   edge_ra;
   logic                            dist_we;
   logic [VB-1:0]                   dist_wa, dist_ra;
   logic [DB-1:0]                   dist_wd;
   logic [VB-1:0]                   idx_v;
   logic [DB:0]                     key_j, cand_sum;
   logic [DB-1:0]                   cand;
   logic                            rsp_load;

   logic                            rsp_valid_ff;
   logic [VB-1:0]                   rsp_vertex_ff;
   logic [DB-1:0]                   rsp_distance_ff;
   logic                            rsp_reachable_ff, rsp_last_ff;

   assign idx_v = idx_ff[VB-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ddsp_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.action)
                  ddsp_pkg::ACT_CLEAR: state_in = ddsp_pkg::ST_CLEAR;
                  ddsp_pkg::ACT_RUN:   state_in = ddsp_pkg::ST_INIT;
                  default:             state_in = ddsp_pkg::ST_IDLE;
               endcase
            end
         end
         ddsp_pkg::ST_CLEAR:
            if (sweep_ff[ddsp_pkg::EdgeBits]) state_in = ddsp_pkg::ST_IDLE;
         ddsp_pkg::ST_INIT:
            state_in = ({1'b0, cmd_ff.src} < cmd_ff.count) ? ddsp_pkg::ST_SCAN
                                                          : ddsp_pkg::ST_EMIT_RD;
         ddsp_pkg::ST_SCAN:
            if (idx_ff == cmd_ff.count - 1'b1) state_in = ddsp_pkg::ST_MARK;
         ddsp_pkg::ST_MARK:
            state_in = reach_ff[pick_ff] ? ddsp_pkg::ST_RELAX_RD : ddsp_pkg::ST_SCAN;
         ddsp_pkg::ST_RELAX_RD:
            state_in = ddsp_pkg::ST_RELAX;
         ddsp_pkg::ST_RELAX: begin
            if (idx_ff == cmd_ff.count - 1'b1) begin
               state_in = (round_ff == cmd_ff.count) ? ddsp_pkg::ST_EMIT_RD
                                                    : ddsp_pkg::ST_SCAN;
            end else begin
               state_in = ddsp_pkg::ST_RELAX_RD;
            end
         end
         ddsp_pkg::ST_EMIT_RD:
            if (!rsp_valid_ff || rsp_ready) state_in = ddsp_pkg::ST_EMIT;
         ddsp_pkg::ST_EMIT:
            state_in = (idx_ff == cmd_ff.count - 1'b1) ? ddsp_pkg::ST_IDLE
                                                      : ddsp_pkg::ST_EMIT_RD;
         default: state_in = ddsp_pkg::ST_IDLE;
      endcase
      // A MARK round that ends the run without relaxing also finishes.
      // The round count is still that of the round being marked here.
      if (state_ff == ddsp_pkg::ST_MARK && !reach_ff[pick_ff] &&
          round_ff == cmd_ff.count - 1'b1) begin
         state_in = ddsp_pkg::ST_EMIT_RD;
      end
   end

   // Datapath and outputs.
   always_comb begin
      cmd_ready    = (state_ff == ddsp_pkg::ST_IDLE);
      cmd_in       = cmd_ff;
      sweep_in     = sweep_ff;
      idx_in       = idx_ff;
      round_in     = round_ff;
      low_in       = low_ff;
      pick_in      = pick_ff;
      pick_dist_in = pick_dist_ff;
      chosen_in    = chosen_ff;
      reach_in     = reach_ff;
      visited_in   = visited_ff;
      edge_we      = 1'b0;
      edge_wa      = {cmd_data.src, cmd_data.dst};
      edge_wd      = {1'b1, cmd_data.weight};
      edge_ra      = {pick_ff, idx_v};
      dist_we      = 1'b0;
      dist_wa      = idx_v;
      dist_wd      = '0;
      dist_ra      = idx_v;
      rsp_load     = 1'b0;
      key_j        = reach_ff[idx_v] ? {1'b0, dist_rd_ff} : {1'b1, {DB{1'b0}}};
      cand_sum     = {1'b0, pick_dist_ff} +
                     (DB+1)'(edge_rd_ff[ddsp_pkg::WeightBits-1:0]);
      cand         = cand_sum[DB] ? ddsp_pkg::DistMax : cand_sum[DB-1:0];

      case (state_ff)
         ddsp_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd_data;
               sweep_in = '0;
               idx_in   = '0;
               round_in = '0;
               if (cmd_data.action == ddsp_pkg::ACT_ADD) begin
                  edge_we = 1'b1;
               end
               reach_in   = '0;
               visited_in = '0;
            end
         end
         ddsp_pkg::ST_CLEAR: begin
            edge_we  = !sweep_ff[ddsp_pkg::EdgeBits];
            edge_wa  = sweep_ff[ddsp_pkg::EdgeBits-1:0];
            edge_wd  = '0;
            sweep_in = sweep_ff + 1'b1;
         end
         ddsp_pkg::ST_INIT: begin
            if ({1'b0, cmd_ff.src} < cmd_ff.count) begin
               reach_in[cmd_ff.src] = 1'b1;
               dist_we = 1'b1;
               dist_wa = cmd_ff.src;
            end
            idx_in = '0;
            low_in = {1'b1, {DB{1'b0}}};
            pick_in = '0;
            dist_ra = '0;
         end
         ddsp_pkg::ST_SCAN: begin
            // dist_rd_ff holds the entry for idx; prefetch the next one.
            if (!visited_ff[idx_v] && key_j <= low_ff) begin
               low_in       = key_j;
               pick_in      = idx_v;
               pick_dist_in = dist_rd_ff;
            end
            dist_ra = VB'(idx_ff + 1'b1);
            idx_in  = (idx_ff == cmd_ff.count - 1'b1) ? '0 : idx_ff + 1'b1;
         end
         ddsp_pkg::ST_MARK: begin
            chosen_in = pick_ff;
            visited_in[pick_ff] = 1'b1;
            round_in = round_ff + 1'b1;
            idx_in = '0;
            low_in = {1'b1, {DB{1'b0}}};
            dist_ra = '0;
            edge_ra = {pick_ff, VB'(0)};
         end
         ddsp_pkg::ST_RELAX_RD: begin
            edge_ra = {chosen_ff, idx_v};
            dist_ra = idx_v;
         end
         ddsp_pkg::ST_RELAX: begin
            if (!visited_ff[idx_v] && edge_rd_ff[ddsp_pkg::WeightBits] &&
                {1'b0, cand} < key_j) begin
               dist_we = 1'b1;
               dist_wd = cand;
               reach_in[idx_v] = 1'b1;
            end
            if (idx_ff == cmd_ff.count - 1'b1) begin
               idx_in  = '0;
               pick_in = '0;
               dist_ra = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ddsp_pkg::ST_EMIT_RD: begin
            dist_ra = idx_v;
         end
         ddsp_pkg::ST_EMIT: begin
            rsp_load = 1'b1;
            idx_in   = idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddsp_pkg::ST_CLEAR;
         reach_ff     <= '0;
         visited_ff   <= '0;
         chosen_ff    <= '0;
         sweep_ff     <= '0;
         idx_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         reach_ff   <= reach_in;
         visited_ff <= visited_in;
         chosen_ff  <= chosen_in;
         sweep_ff   <= sweep_in;
         idx_ff     <= idx_in;
         round_ff   <= round_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      low_ff       <= low_in;
      pick_ff      <= pick_in;
      pick_dist_ff <= pick_dist_in;
      if (rsp_load) begin
         rsp_vertex_ff    <= idx_v;
         rsp_reachable_ff <= reach_ff[idx_v];
         rsp_distance_ff  <= reach_ff[idx_v] ? dist_rd_ff : '0;
         rsp_last_ff      <= (idx_ff == cmd_ff.count - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      edge_rd_ff <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      // A write to the address being read is passed straight through.
      if (dist_we && dist_wa == dist_ra) begin
         dist_rd_ff <= dist_wd;
      end else begin
         dist_rd_ff <= dist_mem[dist_ra];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vertex    = rsp_vertex_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_reachable = rsp_reachable_ff;
   assign rsp_last      = rsp_last_ff;

   `ASSERT_NEXT(a_hold_output, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `ASSERT_CHECK(a_load_free, clock, reset, !rsp_load || !rsp_valid_ff || rsp_ready, "result overwritten")
   `ASSERT_CHECK(a_visit_reach, clock, reset, state_ff != ddsp_pkg::ST_SCAN || (visited_ff & ~reach_ff) == '0 || round_ff != '0, "visited before first round")

endmodule

// File: design/dense_dijkstra_shortest_paths_top.sv
// Clear sweeps the 4096-entry edge store one entry a cycle. Add edge writes the store
// as the engine takes it; unknown or out-of-range items are dropped at entry.
// A run over N vertices from an in-range source does N rounds of a scan and a mark,
// plus a read and a relax step per vertex after a reachable pick. Each result is a
// registered distance read, then a load. Reset is synchronous and active high;
// vertex_count returns to 64 and the edge store is swept clear before any item runs.
// ----------------------------------------------------------------------------
// dense_dijkstra_shortest_paths_top
// Single-source shortest paths over a dense graph of up to 64 vertices.
// ----------------------------------------------------------------------------
module dense_dijkstra_shortest_paths_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [ddsp_pkg::VertexBits-1:0]   req_src_vertex,
   input  logic [ddsp_pkg::VertexBits-1:0]   req_dst_vertex,
   input  logic [ddsp_pkg::WeightBits-1:0]   req_edge_weight,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ddsp_pkg::VertexBits-1:0]   rsp_vertex,
   output logic [ddsp_pkg::DistBits-1:0]     rsp_distance,
   output logic                              rsp_reachable,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ddsp_pkg::CountBits-1:0]    csr_vertex_count
);

   logic [ddsp_pkg::CountBits-1:0] count_ff;
   logic                           cmd_valid, cmd_ready;
   ddsp_pkg::cmd_type              cmd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ddsp_pkg::CountBits'(ddsp_pkg::MaxVertices);
      end else if (csr_valid) begin
         count_ff <= csr_vertex_count;
      end
   end

   ddsp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_src_vertex  (req_src_vertex),
      .req_dst_vertex  (req_dst_vertex),
      .req_edge_weight (req_edge_weight),
      .vertex_count    (count_ff),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd_data        (cmd_data)
   );

   ddsp_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd_data      (cmd_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_vertex    (rsp_vertex),
      .rsp_distance  (rsp_distance),
      .rsp_reachable (rsp_reachable),
      .rsp_last      (rsp_last)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the dense shortest-path block. It clears the graph, adds edges and
// runs from chosen sources under several vertex counts. A local copy of the
// edge store computes the distances that every run should report, and each
// result transfer is checked field by field against them in order.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [ddsp_pkg::VertexBits-1:0] vertex;
      logic [ddsp_pkg::DistBits-1:0]   distance;
      logic                            reachable;
      logic                            last;
   } path_result_type;

   typedef struct {
      ddsp_pkg::action_type            action;
      logic [ddsp_pkg::VertexBits-1:0] src;
      logic [ddsp_pkg::VertexBits-1:0] dst;
      logic [ddsp_pkg::WeightBits-1:0] weight;
   } graph_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = 2'd0;
   logic [ddsp_pkg::VertexBits-1:0] req_src_vertex = '0;
   logic [ddsp_pkg::VertexBits-1:0] req_dst_vertex = '0;
   logic [ddsp_pkg::WeightBits-1:0] req_edge_weight = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ddsp_pkg::VertexBits-1:0] rsp_vertex;
   logic [ddsp_pkg::DistBits-1:0] rsp_distance;
   logic rsp_reachable;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ddsp_pkg::CountBits-1:0] csr_vertex_count = '0;

   graph_cmd_type   pending_cmds[$];
   path_result_type expected_paths[$];

   // Local copy of the graph and the vertex count register.
   logic [ddsp_pkg::WeightBits-1:0] edge_weight_copy[ddsp_pkg::EdgeDepth];
   logic                            edge_on_copy[ddsp_pkg::EdgeDepth];
   int unsigned                     vertex_count_copy = 64;

   int  error_count = 0;
   int  idle_pct = 21;
   bit  cmd_taken = 0;
   bit  stall_request = 0;
   int  stall_left = 0;

   dense_dijkstra_shortest_paths_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_src_vertex(req_src_vertex), .req_dst_vertex(req_dst_vertex),
      .req_edge_weight(req_edge_weight),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_vertex(rsp_vertex),
      .rsp_distance(rsp_distance), .rsp_reachable(rsp_reachable), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_vertex_count(csr_vertex_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Dijkstra with the block's tie rule: the highest unvisited vertex at or
   // below the running minimum wins, unreachable vertices counting as infinity.
   function automatic void predict_paths(int unsigned count, int unsigned source);
      int unsigned path_len[ddsp_pkg::MaxVertices];
      bit          reach[ddsp_pkg::MaxVertices];
      bit          seen[ddsp_pkg::MaxVertices];
      int unsigned n, low, pick, cand, key, inf;
      path_result_type r;
      inf = ddsp_pkg::DistMax + 1;
      n = (count == 0) ? 1 : (count > ddsp_pkg::MaxVertices) ? ddsp_pkg::MaxVertices : count;
      for (int j = 0; j < ddsp_pkg::MaxVertices; j++) begin
         path_len[j] = 0;
         reach[j] = 0;
         seen[j] = 0;
      end
      if (source < n) begin
         reach[source] = 1;
         for (int round = 0; round < n; round++) begin
            low = inf;
            pick = 0;
            for (int j = 0; j < n; j++) begin
               key = reach[j] ? path_len[j] : inf;
               if (!seen[j] && key <= low) begin
                  low = key;
                  pick = j;
               end
            end
            seen[pick] = 1;
            if (reach[pick]) begin
               for (int j = 0; j < n; j++) begin
                  if (!seen[j] && edge_on_copy[pick * ddsp_pkg::MaxVertices + j]) begin
                     cand = path_len[pick] +
                            edge_weight_copy[pick * ddsp_pkg::MaxVertices + j];
                     if (cand > ddsp_pkg::DistMax) cand = ddsp_pkg::DistMax;
                     key = reach[j] ? path_len[j] : inf;
                     if (cand < key) begin
                        path_len[j] = cand;
                        reach[j] = 1;
                     end
                  end
               end
            end
         end
      end
      for (int v = 0; v < n; v++) begin
         r.vertex = ddsp_pkg::VertexBits'(v);
         r.distance = reach[v] ? ddsp_pkg::DistBits'(path_len[v]) : '0;
         r.reachable = reach[v];
         r.last = (v == n - 1);
         expected_paths.push_back(r);
      end
   endfunction

   function automatic void apply_cmd(ddsp_pkg::action_type act, int unsigned s,
                                     int unsigned d, logic [ddsp_pkg::WeightBits-1:0] w);
      int unsigned n;
      n = (vertex_count_copy == 0) ? 1 :
          (vertex_count_copy > ddsp_pkg::MaxVertices) ? ddsp_pkg::MaxVertices :
          vertex_count_copy;
      case (act)
         ddsp_pkg::ACT_CLEAR: begin
            for (int e = 0; e < ddsp_pkg::EdgeDepth; e++) edge_on_copy[e] = 0;
         end
         ddsp_pkg::ACT_ADD: begin
            if (s < n && d < n) begin
               edge_weight_copy[s * ddsp_pkg::MaxVertices + d] = w;
               edge_on_copy[s * ddsp_pkg::MaxVertices + d] = 1;
            end
         end
         ddsp_pkg::ACT_RUN: predict_paths(vertex_count_copy, s);
         default: ;
      endcase
   endfunction

   // Monitor: all transfers are seen at the rising edge.
   always @(posedge clock) begin
      path_result_type exp_r;
      if (!reset) begin
         if (csr_valid && csr_ready) vertex_count_copy = csr_vertex_count;
         if (req_valid && req_ready) begin
            apply_cmd(ddsp_pkg::action_type'(req_action), req_src_vertex, req_dst_vertex,
                      req_edge_weight);
            cmd_taken = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_paths.size() == 0) begin
               $error("unexpected result for vertex %0d", rsp_vertex);
               error_count++;
            end else begin
               exp_r = expected_paths.pop_front();
               if (rsp_vertex !== exp_r.vertex) begin
                  $error("vertex: expected %0d, got %0d", exp_r.vertex, rsp_vertex);
                  error_count++;
               end
               if (rsp_distance !== exp_r.distance) begin
                  $error("distance: expected %0d, got %0d", exp_r.distance, rsp_distance);
                  error_count++;
               end
               if (rsp_reachable !== exp_r.reachable) begin
                  $error("reachable: expected %0d, got %0d", exp_r.reachable,
                         rsp_reachable);
                  error_count++;
               end
               if (rsp_last !== exp_r.last) begin
                  $error("last: expected %0d, got %0d", exp_r.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   // Driver: a new command goes out only once the previous one has transferred.
   always @(negedge clock) begin
      graph_cmd_type c;
      if (!reset && (!req_valid || cmd_taken)) begin
         cmd_taken = 0;
         if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
            c = pending_cmds.pop_front();
            req_action <= c.action;
            req_src_vertex <= c.src;
            req_dst_vertex <= c.dst;
            req_edge_weight <= c.weight;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver, with its own count for a long hold-off.
   always @(negedge clock) begin
      if (stall_request) begin
         stall_request = 0;
         stall_left = 3000;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic send(ddsp_pkg::action_type act, int unsigned s, int unsigned d,
                       int unsigned w);
      graph_cmd_type c;
      c.action = act;
      c.src = ddsp_pkg::VertexBits'(s);
      c.dst = ddsp_pkg::VertexBits'(d);
      c.weight = ddsp_pkg::WeightBits'(w);
      pending_cmds.push_back(c);
   endtask

   // Waits until every command has transferred and every result has come,
   // then for the tail that the caller asks for.
   task automatic settle(int unsigned tail);
      while (pending_cmds.size() > 0 || req_valid || expected_paths.size() > 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_count(int unsigned value);
      settle(4400);
      @(negedge clock);
      csr_vertex_count <= ddsp_pkg::CountBits'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int unsigned count, int unsigned items);
      int unsigned n, made, adds;
      n = (count == 0) ? 1 : (count > ddsp_pkg::MaxVertices) ? ddsp_pkg::MaxVertices : count;
      write_count(count);
      made = 0;
      while (made < items) begin
         if ($urandom_range(99) < 12) begin
            send(ddsp_pkg::ACT_CLEAR, $urandom_range(63), $urandom_range(63), $urandom);
            made++;
         end
         adds = $urandom_range(1, 6);
         for (int k = 0; k < adds; k++) begin
            if ($urandom_range(99) < 15) begin
               // Noise: possibly outside the graph, or an unknown action.
               send($urandom_range(1) ? ddsp_pkg::ACT_ADD : ddsp_pkg::ACT_NONE,
                    $urandom_range(63), $urandom_range(63), $urandom_range(65535));
            end else begin
               send(ddsp_pkg::ACT_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                    $urandom_range(1) ? $urandom_range(65535) : $urandom_range(40));
            end
            made++;
         end
         send(ddsp_pkg::ACT_RUN,
              ($urandom_range(99) < 90) ? $urandom_range(n - 1) : $urandom_range(63),
              $urandom_range(63), $urandom_range(65535));
         made++;
      end
   endtask

   initial begin
      for (int e = 0; e < ddsp_pkg::EdgeDepth; e++) begin
         edge_on_copy[e] = 0;
         edge_weight_copy[e] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      write_count(64);
      send(ddsp_pkg::ACT_CLEAR, 0, 0, 0);
      send(ddsp_pkg::ACT_ADD, 0, 63, 65535);
      send(ddsp_pkg::ACT_ADD, 63, 0, 0);
      send(ddsp_pkg::ACT_ADD, 0, 1, 1);
      send(ddsp_pkg::ACT_ADD, 1, 2, 2);
      send(ddsp_pkg::ACT_ADD, 5, 7, 10);
      send(ddsp_pkg::ACT_ADD, 5, 7, 3);
      send(ddsp_pkg::ACT_ADD, 2, 5, 0);
      send(ddsp_pkg::ACT_ADD, 63, 62, 65535);
      send(ddsp_pkg::ACT_NONE, 63, 63, 65535);
      send(ddsp_pkg::ACT_RUN, 0, 0, 0);
      send(ddsp_pkg::ACT_RUN, 63, 63, 65535);
      write_count(4);
      send(ddsp_pkg::ACT_ADD, 10, 2, 7);
      send(ddsp_pkg::ACT_ADD, 2, 10, 7);
      send(ddsp_pkg::ACT_ADD, 3, 1, 4);
      send(ddsp_pkg::ACT_RUN, 10, 0, 0);
      send(ddsp_pkg::ACT_RUN, 3, 0, 0);
      write_count(0);
      send(ddsp_pkg::ACT_RUN, 0, 0, 0);
      write_count(127);
      send(ddsp_pkg::ACT_RUN, 63, 0, 0);

      // Random part. The receiver holds off while runs keep coming in the
      // second phase, and the third has no idling at all.
      random_phase(6, 18);
      write_count(12);
      stall_request = 1;
      for (int k = 0; k < 6; k++) send(ddsp_pkg::ACT_RUN, $urandom_range(11), 0, 0);
      random_phase(12, 18);
      settle(0);
      idle_pct = 0;
      random_phase(3, 18);
      settle(0);
      idle_pct = 21;
      random_phase(64, 16);
      random_phase(9, 18);
      random_phase(1, 8);
      random_phase(40, 16);

      settle(300);
      if (error_count == 0 && expected_paths.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
